### hw/rtl/c3ac_pkg.sv
// Shared constants, types and helpers of the 3x3 convolution block.
package c3ac_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
	localparam int COEF_BITS  = 8;
	localparam int PIX_W      = 8;
	localparam int WIDTH_W    = 12;
	localparam int HEIGHT_W   = 16;
	localparam int COEF_ROW_W = 24;
	localparam int KDIM       = 3;
	localparam int MIN_DIM    = 3;
	localparam int PIX_MAX    = 255;
	localparam int TOTAL_W    = CNT_W + HEIGHT_W;
	localparam int PROD_W     = COEF_BITS + PIX_W + 1;
	localparam int SUM_W      = PROD_W + 4;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WIDTH    = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_COEF_TOP = 3'd2,
		REG_COEF_MID = 3'd3,
		REG_COEF_BOT = 3'd4
	} reg_idx_t;

	// Effective frame geometry and kernel as seen by the datapath.
	typedef struct packed {
		logic [CNT_W-1:0]                     width;
		logic [HEIGHT_W-1:0]                  height;
		logic [TOTAL_W-1:0]                   total;
		logic [KDIM-1:0][COEF_ROW_W-1:0]      coef;
	} cfg_t;

	// Per-item control decided when the item is taken in.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              emit;
		logic              inner;
		logic              last;
	} tag_t;

	typedef struct packed {
		logic v_s1;
		logic v_s2;
		logic byp_s1;
	} dp_stat_t;

	function automatic logic signed [COEF_BITS-1:0] coef_at(
		input logic [COEF_ROW_W-1:0] row,
		input int                    pos
	);
		coef_at = signed'(row[pos*COEF_BITS +: COEF_BITS]);
	endfunction

endpackage

### hw/rtl/c3ac_if.sv
// Stream interfaces for input pixels and filtered results.
interface c3ac_pix_if import c3ac_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;
	logic             start_of_frame;
	logic             is_padding;

	modport source (output valid, pixel_in, start_of_frame, is_padding, input ready);
	modport sink   (input valid, pixel_in, start_of_frame, is_padding, output ready);
endinterface

interface c3ac_res_if import c3ac_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             last_of_frame;

	modport source (output valid, pixel_out, last_of_frame, input ready);
	modport sink   (input valid, pixel_out, last_of_frame, output ready);
endinterface

### hw/rtl/conv3x3_abs_clamp.sv
// Streaming 3x3 convolution with absolute value and clamp; one pixel per clock
// while the output is not stalled. A result passes the read stage, the product
// stage and the output register. Each line store is read once and written once
// per pixel, and the window advances by one column per pixel.
// Reset loads the default geometry and zero kernel and clears counters and window;
// line stores are not cleared, as unwritten columns only feed border outputs.
module conv3x3_abs_clamp import c3ac_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	c3ac_pix_if.sink              video,
	c3ac_res_if.source            filtered,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
	cfg_t             cfg;
	tag_t             tag;
	dp_stat_t         stat;
	logic             accept;
	logic             in_ready;
	logic [PIX_W-1:0] px;

	assign accept      = video.valid && in_ready;
	assign video.ready = in_ready;
	assign px          = video.is_padding ? '0 : video.pixel_in;

	c3ac_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	c3ac_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sof    (video.start_of_frame),
		.cfg    (cfg),
		.tag    (tag)
	);

	c3ac_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.px        (px),
		.tag       (tag),
		.cfg       (cfg),
		.in_ready  (in_ready),
		.out_valid (filtered.valid),
		.out_ready (filtered.ready),
		.out_pixel (filtered.pixel_out),
		.out_last  (filtered.last_of_frame),
		.stat      (stat)
	);

	// Input is held back only when every stage is full and the output is stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!video.ready |-> (filtered.valid && !filtered.ready && stat.v_s1 && stat.v_s2))
		else $error("input stalled without output back-pressure");

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> stat.v_s1)
		else $error("accepted transaction missing from the read stage");

	a_bypass_valid: assert property (@(posedge clk) disable iff (!arst_n)
		stat.byp_s1 |-> stat.v_s1)
		else $error("line store bypass without an item in the read stage");
endmodule

### hw/rtl/c3ac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module c3ac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### hw/rtl/c3ac_regs.sv
// APB configuration registers and derived frame geometry.
module c3ac_regs import c3ac_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);
	logic [WIDTH_W-1:0]              width_q;
	logic [HEIGHT_W-1:0]             height_q;
	logic [KDIM-1:0][COEF_ROW_W-1:0] coef_q;
	logic [CNT_W-1:0]                w_eff;
	logic [HEIGHT_W-1:0]             h_eff;
	logic [REG_IDX_W-1:0]            idx;
	logic                            wr;

	assign pready = 1'b1;
	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(RESET_WIDTH);
			height_q <= HEIGHT_W'(RESET_HEIGHT);
			coef_q   <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_WIDTH:    width_q   <= pwdata[WIDTH_W-1:0];
				REG_HEIGHT:   height_q  <= pwdata[HEIGHT_W-1:0];
				REG_COEF_TOP: coef_q[0] <= pwdata[COEF_ROW_W-1:0];
				REG_COEF_MID: coef_q[1] <= pwdata[COEF_ROW_W-1:0];
				REG_COEF_BOT: coef_q[2] <= pwdata[COEF_ROW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (int'(width_q) < MIN_DIM) begin
			w_eff = CNT_W'(MIN_DIM);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = CNT_W'(MAX_WIDTH);
		end else begin
			w_eff = CNT_W'(width_q);
		end
		if (int'(height_q) < MIN_DIM) begin
			h_eff = HEIGHT_W'(MIN_DIM);
		end else begin
			h_eff = height_q;
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:    prdata = APB_DATA_W'(width_q);
			REG_HEIGHT:   prdata = APB_DATA_W'(height_q);
			REG_COEF_TOP: prdata = APB_DATA_W'(coef_q[0]);
			REG_COEF_MID: prdata = APB_DATA_W'(coef_q[1]);
			REG_COEF_BOT: prdata = APB_DATA_W'(coef_q[2]);
			default:      prdata = '0;
		endcase
	end

	// Pixel count of a frame, valid in the cycle right after a register write.
	assign cfg.width  = w_eff;
	assign cfg.height = h_eff;
	assign cfg.total  = TOTAL_W'(w_eff) * TOTAL_W'(h_eff);
	assign cfg.coef   = coef_q;
endmodule

### hw/rtl/c3ac_seq.sv
// Column, row and output counters; classifies each accepted pixel.
module c3ac_seq import c3ac_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic sof,
	input  cfg_t cfg,
	output tag_t tag
);
	logic [ADDR_W-1:0]   col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [TOTAL_W-1:0]  oc_q;
	logic [ADDR_W-1:0]   col;
	logic [HEIGHT_W-1:0] row;
	logic [TOTAL_W-1:0]  oc;
	logic [CNT_W-1:0]    colz;
	logic                wrap;

	// A start of frame clears the counters before the item is placed.
	assign col  = sof ? '0 : col_q;
	assign row  = sof ? '0 : row_q;
	assign oc   = sof ? '0 : oc_q;
	assign colz = CNT_W'(col);
	assign wrap = (colz + CNT_W'(1)) >= cfg.width;

	assign tag.addr  = col;
	assign tag.emit  = ((row >= HEIGHT_W'(2)) || (row >= HEIGHT_W'(1) && col != '0))
		&& (oc < cfg.total);
	// The window is centered one row up and one column left of the new pixel.
	assign tag.inner = (row >= HEIGHT_W'(2)) && (row <= cfg.height - HEIGHT_W'(1))
		&& (colz >= CNT_W'(2)) && (colz <= cfg.width - CNT_W'(1));
	assign tag.last  = oc == (cfg.total - TOTAL_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			oc_q  <= '0;
		end else if (accept) begin
			if (wrap) begin
				col_q <= '0;
				row_q <= (row != '1) ? row + HEIGHT_W'(1) : row;
			end else begin
				col_q <= col + ADDR_W'(1);
				row_q <= row;
			end
			oc_q <= tag.emit ? oc + TOTAL_W'(1) : oc;
		end
	end
endmodule

### hw/rtl/c3ac_dp.sv
// Line stores, 3x3 window, multiply-accumulate pipeline and output register.
module c3ac_dp import c3ac_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [PIX_W-1:0] px,
	input  tag_t             tag,
	input  cfg_t             cfg,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] out_pixel,
	output logic             out_last,
	output dp_stat_t         stat
);
	logic                     en_s1, en_s2, en_out, s1_adv, s2_adv;
	logic                     v_s1, v_s2, out_v_q;
	logic [ADDR_W-1:0]        addr_s1;
	logic [PIX_W-1:0]         px_s1;
	logic                     emit_s1, inner_s1, last_s1;
	logic                     byp_s1;
	logic [PIX_W-1:0]         byp_a_s1, byp_b_s1;
	logic [PIX_W-1:0]         rd_a, rd_b, top_eff, mid_eff;
	logic [PIX_W-1:0]         win_q    [KDIM][KDIM];
	logic [PIX_W-1:0]         win_next [KDIM][KDIM];
	logic signed [PROD_W-1:0] prod_c   [KDIM][KDIM];
	logic signed [PROD_W-1:0] prod_s2  [KDIM][KDIM];
	logic                     emit_s2, inner_s2, last_s2;
	logic signed [SUM_W-1:0]  sum_c;
	logic [SUM_W-1:0]         mag_c;
	logic [PIX_W-1:0]         clamp_c;
	logic [PIX_W-1:0]         pix_q;
	logic                     last_q;

	assign en_out   = !out_v_q || out_ready;
	assign en_s2    = !v_s2 || en_out;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign s1_adv   = v_s1 && en_s2;
	assign s2_adv   = v_s2 && en_out;

	// Store a holds the row two above, store b the row above.
	c3ac_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_a (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (addr_s1),
		.wdata (mid_eff),
		.re    (accept),
		.raddr (tag.addr),
		.rdata (rd_a)
	);

	c3ac_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_b (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (addr_s1),
		.wdata (px_s1),
		.re    (accept),
		.raddr (tag.addr),
		.rdata (rd_b)
	);

	// A read that meets the write-back of the previous item at the same column
	// (start of frame right after column zero) takes the written data instead.
	assign top_eff = byp_s1 ? byp_a_s1 : rd_a;
	assign mid_eff = byp_s1 ? byp_b_s1 : rd_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			byp_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1   <= accept;
			byp_s1 <= accept && s1_adv && (addr_s1 == tag.addr);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1  <= tag.addr;
			px_s1    <= px;
			emit_s1  <= tag.emit;
			inner_s1 <= tag.inner;
			last_s1  <= tag.last;
			byp_a_s1 <= mid_eff;
			byp_b_s1 <= px_s1;
		end
	end

	always_comb begin
		for (int k = 0; k < KDIM; k++) begin
			win_next[k][0] = win_q[k][1];
			win_next[k][1] = win_q[k][2];
		end
		win_next[0][2] = top_eff;
		win_next[1][2] = mid_eff;
		win_next[2][2] = px_s1;
		for (int k = 0; k < KDIM; k++) begin
			for (int l = 0; l < KDIM; l++) begin
				prod_c[k][l] = PROD_W'(coef_at(cfg.coef[k], l))
					* PROD_W'(signed'({1'b0, win_next[k][l]}));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KDIM; k++) begin
				for (int l = 0; l < KDIM; l++) begin
					win_q[k][l] <= '0;
				end
			end
		end else if (s1_adv) begin
			win_q <= win_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			prod_s2  <= prod_c;
			emit_s2  <= emit_s1;
			inner_s2 <= inner_s1;
			last_s2  <= last_s1;
		end
	end

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < KDIM; k++) begin
			for (int l = 0; l < KDIM; l++) begin
				sum_c = sum_c + SUM_W'(prod_s2[k][l]);
			end
		end
		mag_c   = sum_c[SUM_W-1] ? unsigned'(-sum_c) : unsigned'(sum_c);
		clamp_c = (mag_c >= SUM_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : mag_c[PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= v_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && emit_s2) begin
			pix_q  <= inner_s2 ? clamp_c : '0;
			last_q <= last_s2;
		end
	end

	assign out_valid   = out_v_q;
	assign out_pixel   = pix_q;
	assign out_last    = last_q;
	assign stat.v_s1   = v_s1;
	assign stat.v_s2   = v_s2;
	assign stat.byp_s1 = byp_s1;
endmodule
